// ----- rtl/core/cp0e_pkg.sv -----
package cp0e_pkg;

	// Item kinds.
	localparam logic [3:0] MODE_COP_UNUSABLE = 4'd0;
	localparam logic [3:0] MODE_DTLB         = 4'd1;
	localparam logic [3:0] MODE_ITLB         = 4'd2;
	localparam logic [3:0] MODE_INTERRUPT    = 4'd3;
	localparam logic [3:0] MODE_SYSCALL      = 4'd4;
	localparam logic [3:0] MODE_WATCH        = 4'd5;
	localparam logic [3:0] MODE_COLD_RESET   = 4'd6;
	localparam logic [3:0] MODE_REG_WRITE    = 4'd7;
	localparam logic [3:0] MODE_REG_READ     = 4'd8;

	// Register selects for the access port.
	localparam logic [3:0] SEL_STATUS   = 4'd0;
	localparam logic [3:0] SEL_CAUSE    = 4'd1;
	localparam logic [3:0] SEL_EPC      = 4'd2;
	localparam logic [3:0] SEL_ERROREPC = 4'd3;
	localparam logic [3:0] SEL_ENTRYHI  = 4'd4;
	localparam logic [3:0] SEL_CONTEXT  = 4'd5;
	localparam logic [3:0] SEL_XCONTEXT = 4'd6;
	localparam logic [3:0] SEL_BADVADDR = 4'd7;
	localparam logic [3:0] SEL_CONFIG   = 4'd8;
	localparam logic [3:0] SEL_RANDOM   = 4'd9;

	// Cause exception codes.
	localparam logic [4:0] EXC_INT  = 5'd0;
	localparam logic [4:0] EXC_MOD  = 5'd1;
	localparam logic [4:0] EXC_TLBL = 5'd2;
	localparam logic [4:0] EXC_TLBS = 5'd3;
	localparam logic [4:0] EXC_SYS  = 5'd8;
	localparam logic [4:0] EXC_CPU  = 5'd11;
	localparam logic [4:0] EXC_WATCH = 5'd23;

	// Status and Cause bit positions.
	localparam int ST_EXL_BIT   = 1;
	localparam int ST_ERL_BIT   = 2;
	localparam int ST_BEV_BIT   = 22;
	localparam int CAUSE_CE_BIT = 28;
	localparam int CAUSE_BD_BIT = 31;

	// Vector bases and offsets.
	localparam logic [63:0] VEC_BEV_BASE  = 64'hFFFF_FFFF_BFC0_0200;
	localparam logic [63:0] VEC_NORM_BASE = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] VEC_COLD      = 64'hFFFF_FFFF_BFC0_0000;
	localparam logic [8:0]  OFFS_GENERAL  = 9'h180;
	localparam logic [8:0]  OFFS_TLB      = 9'h000;
	localparam logic [8:0]  OFFS_XTLB     = 9'h080;

	// Cold reset masks.
	localparam logic [31:0] COLD_ST_CLR  = 32'h0830_0000;
	localparam logic [31:0] COLD_ST_SET  = 32'h0040_0004;
	localparam logic [31:0] COLD_CFG_KEEP = 32'h0000_800F;
	localparam logic [31:0] COLD_CFG_SET = 32'h7006_E460;
	localparam logic [4:0]  COLD_RANDOM  = 5'd31;

	typedef struct packed {
		logic [31:0] status;
		logic [31:0] cause;
		logic [63:0] exc_pc;
		logic [63:0] error_pc;
		logic [63:0] entry_hi;
		logic [63:0] context_r;
		logic [63:0] xcontext_r;
		logic [63:0] bad_addr;
		logic [31:0] machine_config;
		logic [4:0]  random_val;
	} cp0e_regs_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [63:0] fault_pc;
		logic        in_delay_slot;
		logic [63:0] bad_vaddr;
		logic        is_store;
		logic        tlb_miss;
		logic        tlb_invalid;
		logic [7:0]  segment_mask;
		logic [3:0]  reg_select;
		logic [63:0] write_data;
	} cp0e_item_t;

	typedef struct packed {
		logic [63:0] next_pc;
		logic [4:0]  exception_code;
		logic [63:0] read_data;
	} cp0e_result_t;

endpackage

// ----- rtl/core/cp0e_exec.sv -----
module cp0e_exec (
	input  cp0e_pkg::cp0e_item_t   item,
	input  cp0e_pkg::cp0e_regs_t   regs,
	output cp0e_pkg::cp0e_regs_t   regs_nxt,
	output cp0e_pkg::cp0e_result_t res
);
	import cp0e_pkg::*;

	logic        exl;
	logic        wide;
	logic [31:0] cause;
	logic [31:0] cold_status;
	logic [63:0] epc;
	logic [63:0] tlb_addr;
	logic [8:0]  offs;
	logic [4:0]  code;

	assign exl = regs.status[ST_EXL_BIT];
	assign wide = |(regs.status[7:0] & item.segment_mask);
	assign tlb_addr = (item.mode == MODE_DTLB) ? item.bad_vaddr : item.fault_pc;
	assign cold_status = (regs.status & ~COLD_ST_CLR) | COLD_ST_SET;

	always_comb begin
		regs_nxt = regs;
		res = '0;
		cause = regs.cause;
		epc = regs.exc_pc;
		offs = OFFS_GENERAL;
		code = EXC_INT;
		unique case (item.mode) inside
			MODE_COP_UNUSABLE, MODE_DTLB, MODE_ITLB, MODE_INTERRUPT,
			MODE_SYSCALL, MODE_WATCH: begin
				// EPC and the delay-slot bit are only captured on a first-level entry.
				if (!exl) begin
					cause[CAUSE_BD_BIT] = item.in_delay_slot;
					epc = item.in_delay_slot ? item.fault_pc - 64'd4 : item.fault_pc;
				end
				cause[7:0] = '0;
				case (item.mode)
					MODE_DTLB, MODE_ITLB: begin
						if (item.tlb_miss && !exl) begin
							offs = wide ? OFFS_XTLB : OFFS_TLB;
						end
						if (item.mode == MODE_ITLB) begin
							code = EXC_TLBL;
						end else if (item.tlb_miss || item.tlb_invalid) begin
							code = item.is_store ? EXC_TLBS : EXC_TLBL;
						end else begin
							code = EXC_MOD;
						end
						if (wide) begin
							regs_nxt.entry_hi = {tlb_addr[63:62], 22'd0, tlb_addr[39:13],
								5'd0, regs.entry_hi[7:0]};
							regs_nxt.xcontext_r = {regs.xcontext_r[63:33], tlb_addr[63:62],
								tlb_addr[39:13], regs.xcontext_r[3:0]};
						end else begin
							regs_nxt.entry_hi = {{32{tlb_addr[31]}}, tlb_addr[31:13],
								5'd0, regs.entry_hi[7:0]};
							regs_nxt.context_r = {regs.context_r[63:23], tlb_addr[31:13],
								regs.context_r[3:0]};
						end
						regs_nxt.bad_addr = tlb_addr;
					end
					MODE_COP_UNUSABLE: begin
						cause[CAUSE_CE_BIT] = 1'b1;
						code = EXC_CPU;
					end
					MODE_SYSCALL: code = EXC_SYS;
					MODE_WATCH:   code = EXC_WATCH;
					default:      code = EXC_INT;
				endcase
				cause[6:2] = code;
				if (exl) begin
					regs_nxt.status = regs.status | (32'd1 << ST_ERL_BIT);
					regs_nxt.error_pc = epc;
				end else begin
					regs_nxt.status = regs.status | (32'd1 << ST_EXL_BIT);
					regs_nxt.exc_pc = epc;
				end
				regs_nxt.cause = cause;
				res.next_pc = (regs.status[ST_BEV_BIT] ? VEC_BEV_BASE : VEC_NORM_BASE)
					+ {55'd0, offs};
			end
			MODE_COLD_RESET: begin
				regs_nxt.machine_config = (regs.machine_config & COLD_CFG_KEEP)
					| COLD_CFG_SET;
				regs_nxt.random_val = COLD_RANDOM;
				// EPC is carried over unchanged, so only ErrorEPC can move here.
				if (exl) begin
					regs_nxt.status = cold_status | (32'd1 << ST_ERL_BIT);
					regs_nxt.error_pc = regs.exc_pc;
				end else begin
					regs_nxt.status = cold_status | (32'd1 << ST_EXL_BIT);
				end
				res.next_pc = VEC_COLD;
			end
			MODE_REG_WRITE: begin
				unique case (item.reg_select)
					SEL_STATUS:   regs_nxt.status = item.write_data[31:0];
					SEL_CAUSE:    regs_nxt.cause = item.write_data[31:0];
					SEL_EPC:      regs_nxt.exc_pc = item.write_data;
					SEL_ERROREPC: regs_nxt.error_pc = item.write_data;
					SEL_ENTRYHI:  regs_nxt.entry_hi = item.write_data;
					SEL_CONTEXT:  regs_nxt.context_r = item.write_data;
					SEL_XCONTEXT: regs_nxt.xcontext_r = item.write_data;
					SEL_BADVADDR: regs_nxt.bad_addr = item.write_data;
					SEL_CONFIG:   regs_nxt.machine_config = item.write_data[31:0];
					SEL_RANDOM:   regs_nxt.random_val = item.write_data[4:0];
					default: ;
				endcase
			end
			MODE_REG_READ: begin
				unique case (item.reg_select)
					SEL_STATUS:   res.read_data = {32'd0, regs.status};
					SEL_CAUSE:    res.read_data = {32'd0, regs.cause};
					SEL_EPC:      res.read_data = regs.exc_pc;
					SEL_ERROREPC: res.read_data = regs.error_pc;
					SEL_ENTRYHI:  res.read_data = regs.entry_hi;
					SEL_CONTEXT:  res.read_data = regs.context_r;
					SEL_XCONTEXT: res.read_data = regs.xcontext_r;
					SEL_BADVADDR: res.read_data = regs.bad_addr;
					SEL_CONFIG:   res.read_data = {32'd0, regs.machine_config};
					SEL_RANDOM:   res.read_data = {59'd0, regs.random_val};
					default:      res.read_data = '0;
				endcase
			end
			default: ;
		endcase
		res.exception_code = regs_nxt.cause[6:2];
	end

endmodule

// ----- rtl/core/cp0_exception_entry_unit_top.sv -----
// An accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle unless the output stalls; the input register and the result register
// form a two-stage pipeline, and the register file is updated in the same edge that loads the result.
// Reset: arst_n clears all coprocessor registers to zero and empties both stages.
// The TLB modify flag does not change the outcome: a data TLB item without miss or
// invalid always reports a modify fault.
module cp0_exception_entry_unit_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  mode,
	input  logic [63:0] fault_pc,
	input  logic        in_delay_slot,
	input  logic [63:0] bad_vaddr,
	input  logic        is_store,
	input  logic        tlb_miss,
	input  logic        tlb_invalid,
	input  logic        tlb_modified,
	input  logic [7:0]  segment_mask,
	input  logic [3:0]  reg_select,
	input  logic [63:0] write_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] next_pc,
	output logic [4:0]  exception_code,
	output logic [63:0] read_data
);
	import cp0e_pkg::*;

	cp0e_item_t   item_in;
	cp0e_item_t   item_s1;
	logic         valid_s1;
	logic         advance;
	cp0e_regs_t   regs_q;
	cp0e_regs_t   regs_nxt;
	cp0e_result_t res;
	cp0e_result_t res_q;
	logic         out_valid_q;

	assign item_in = '{
		mode:          mode,
		fault_pc:      fault_pc,
		in_delay_slot: in_delay_slot,
		bad_vaddr:     bad_vaddr,
		is_store:      is_store,
		tlb_miss:      tlb_miss,
		tlb_invalid:   tlb_invalid,
		segment_mask:  segment_mask,
		reg_select:    reg_select,
		write_data:    write_data
	};

	// The item in stage one moves on when the result register is free or being drained.
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	cp0e_exec u_exec (
		.item     (item_s1),
		.regs     (regs_q),
		.regs_nxt (regs_nxt),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			regs_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				regs_q <= regs_nxt;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_in;
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign next_pc = res_q.next_pc;
	assign exception_code = res_q.exception_code;
	assign read_data = res_q.read_data;

endmodule

// ----- tb/sv/tb_cp0_exception_entry_unit_top.sv -----
`timescale 1ns / 1ps

module tb_cp0_exception_entry_unit_top;
	import cp0e_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int MAX_PRINTED = 40;

	typedef struct packed {
		logic [3:0]  mode;
		logic [63:0] fault_pc;
		logic        bd;
		logic [63:0] bad_vaddr;
		logic        is_store;
		logic        miss;
		logic        invalid;
		logic        modified;
		logic [7:0]  segmask;
		logic [3:0]  sel;
		logic [63:0] wdata;
	} cp0_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        out_ready = 1'b0;
	cp0_req_t    cur_req = '0;
	logic [3:0]  mode;
	logic [63:0] fault_pc;
	logic        in_delay_slot;
	logic [63:0] bad_vaddr;
	logic        is_store;
	logic        tlb_miss;
	logic        tlb_invalid;
	logic        tlb_modified;
	logic [7:0]  segment_mask;
	logic [3:0]  reg_select;
	logic [63:0] write_data;
	logic [63:0] next_pc;
	logic [4:0]  exception_code;
	logic [63:0] read_data;

	assign mode          = cur_req.mode;
	assign fault_pc      = cur_req.fault_pc;
	assign in_delay_slot = cur_req.bd;
	assign bad_vaddr     = cur_req.bad_vaddr;
	assign is_store      = cur_req.is_store;
	assign tlb_miss      = cur_req.miss;
	assign tlb_invalid   = cur_req.invalid;
	assign tlb_modified  = cur_req.modified;
	assign segment_mask  = cur_req.segmask;
	assign reg_select    = cur_req.sel;
	assign write_data    = cur_req.wdata;

	cp0_exception_entry_unit_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.fault_pc(fault_pc),
		.in_delay_slot(in_delay_slot),
		.bad_vaddr(bad_vaddr),
		.is_store(is_store),
		.tlb_miss(tlb_miss),
		.tlb_invalid(tlb_invalid),
		.tlb_modified(tlb_modified),
		.segment_mask(segment_mask),
		.reg_select(reg_select),
		.write_data(write_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.next_pc(next_pc),
		.exception_code(exception_code),
		.read_data(read_data)
	);

	always #5 clk = ~clk;

	// Predicted coprocessor register file.
	logic [31:0] st_status = '0;
	logic [31:0] st_cause = '0;
	logic [63:0] st_epc = '0;
	logic [63:0] st_errorepc = '0;
	logic [63:0] st_entryhi = '0;
	logic [63:0] st_ctx = '0;
	logic [63:0] st_xctx = '0;
	logic [63:0] st_badvaddr = '0;
	logic [31:0] st_config = '0;
	logic [4:0]  st_random = '0;

	cp0e_result_t pending_results[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;
	int n_errors = 0;
	int n_checked = 0;
	int n_events = 0;
	int n_writes = 0;
	int n_reads = 0;
	int n_other = 0;

	function automatic cp0e_result_t cp0_step_result(input cp0_req_t r);
		logic [31:0] cause;
		logic [31:0] status;
		logic [63:0] epc;
		logic [63:0] va;
		logic [31:0] lo;
		logic [8:0]  offs;
		logic [4:0]  code;
		logic        wide;
		cp0e_result_t res;
		res = '0;
		cause = st_cause;
		status = st_status;
		epc = st_epc;
		if (r.mode <= MODE_COLD_RESET) begin
			if (r.mode == MODE_COLD_RESET) begin
				status = (st_status & ~COLD_ST_CLR) | COLD_ST_SET;
				st_config = (st_config & COLD_CFG_KEEP) | COLD_CFG_SET;
				st_random = COLD_RANDOM;
				res.next_pc = VEC_COLD;
			end else begin
				// EPC and the delay-slot bit are only captured on a first-level entry.
				if (!status[ST_EXL_BIT]) begin
					cause[CAUSE_BD_BIT] = r.bd;
					epc = r.bd ? r.fault_pc - 64'd4 : r.fault_pc;
				end
				cause[7:0] = '0;
				offs = OFFS_GENERAL;
				case (r.mode)
					MODE_DTLB, MODE_ITLB: begin
						wide = (status[7:0] & r.segmask) != 8'd0;
						if (r.miss && !status[ST_EXL_BIT])
							offs = wide ? OFFS_XTLB : OFFS_TLB;
						if (r.mode == MODE_DTLB) begin
							va = r.bad_vaddr;
							code = !(r.miss || r.invalid) ? EXC_MOD :
								(r.is_store ? EXC_TLBS : EXC_TLBL);
						end else begin
							va = r.fault_pc;
							code = EXC_TLBL;
						end
						if (wide) begin
							st_entryhi = {va[63:62], 22'd0, va[39:13], 5'd0, st_entryhi[7:0]};
							st_xctx[32:4] = {va[63:62], va[39:13]};
						end else begin
							lo = {va[31:13], 5'd0, st_entryhi[7:0]};
							st_entryhi = {{32{lo[31]}}, lo};
							st_ctx[22:4] = va[31:13];
						end
						st_badvaddr = va;
						cause[6:2] = code;
					end
					MODE_COP_UNUSABLE: begin
						cause[CAUSE_CE_BIT] = 1'b1;
						cause[6:2] = EXC_CPU;
					end
					MODE_SYSCALL: cause[6:2] = EXC_SYS;
					MODE_WATCH: cause[6:2] = EXC_WATCH;
					default: cause[6:2] = EXC_INT;
				endcase
				res.next_pc = (status[ST_BEV_BIT] ? VEC_BEV_BASE : VEC_NORM_BASE) +
					{55'd0, offs};
			end
			// A nested entry goes to the error level and keeps EPC untouched.
			if (status[ST_EXL_BIT]) begin
				st_status = status | (32'd1 << ST_ERL_BIT);
				st_errorepc = epc;
			end else begin
				st_status = status | (32'd1 << ST_EXL_BIT);
				st_epc = epc;
			end
			st_cause = cause;
		end else if (r.mode == MODE_REG_WRITE) begin
			case (r.sel)
				SEL_STATUS:   st_status = r.wdata[31:0];
				SEL_CAUSE:    st_cause = r.wdata[31:0];
				SEL_EPC:      st_epc = r.wdata;
				SEL_ERROREPC: st_errorepc = r.wdata;
				SEL_ENTRYHI:  st_entryhi = r.wdata;
				SEL_CONTEXT:  st_ctx = r.wdata;
				SEL_XCONTEXT: st_xctx = r.wdata;
				SEL_BADVADDR: st_badvaddr = r.wdata;
				SEL_CONFIG:   st_config = r.wdata[31:0];
				SEL_RANDOM:   st_random = r.wdata[4:0];
				default: ;
			endcase
		end else if (r.mode == MODE_REG_READ) begin
			case (r.sel)
				SEL_STATUS:   res.read_data = {32'd0, st_status};
				SEL_CAUSE:    res.read_data = {32'd0, st_cause};
				SEL_EPC:      res.read_data = st_epc;
				SEL_ERROREPC: res.read_data = st_errorepc;
				SEL_ENTRYHI:  res.read_data = st_entryhi;
				SEL_CONTEXT:  res.read_data = st_ctx;
				SEL_XCONTEXT: res.read_data = st_xctx;
				SEL_BADVADDR: res.read_data = st_badvaddr;
				SEL_CONFIG:   res.read_data = {32'd0, st_config};
				SEL_RANDOM:   res.read_data = {59'd0, st_random};
				default:      res.read_data = '0;
			endcase
		end
		res.exception_code = st_cause[6:2];
		return res;
	endfunction

	function automatic cp0_req_t random_fields(input logic [3:0] m);
		cp0_req_t r;
		r.mode = m;
		r.fault_pc = {$urandom, $urandom};
		if ($urandom_range(0, 9) == 0)
			r.fault_pc = 64'($urandom_range(0, 3));
		r.bd = 1'($urandom_range(0, 1));
		r.bad_vaddr = {$urandom, $urandom};
		r.is_store = 1'($urandom_range(0, 1));
		r.miss = 1'($urandom_range(0, 1));
		r.invalid = 1'($urandom_range(0, 1));
		r.modified = 1'($urandom_range(0, 1));
		r.segmask = 8'($urandom_range(0, 255));
		r.sel = 4'($urandom_range(SEL_STATUS, SEL_RANDOM));
		if ($urandom_range(0, 9) == 0)
			r.sel = 4'($urandom_range(SEL_RANDOM + 1, 15));
		r.wdata = {$urandom, $urandom};
		return r;
	endfunction

	function automatic cp0_req_t random_cp0_item();
		cp0_req_t r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			r = random_fields(MODE_DTLB);
		else if (pick < 32)
			r = random_fields(MODE_ITLB);
		else if (pick < 44)
			r = random_fields(4'($urandom_range(MODE_COP_UNUSABLE, MODE_WATCH)));
		else if (pick < 47)
			r = random_fields(MODE_COLD_RESET);
		else if (pick < 73) begin
			r = random_fields(MODE_REG_WRITE);
			// Status writes mostly drop back to the base level so that
			// following exceptions take the first-level path.
			if ($urandom_range(0, 1) == 0) begin
				r.sel = SEL_STATUS;
				if ($urandom_range(0, 9) < 7) begin
					r.wdata[ST_EXL_BIT] = 1'b0;
					r.wdata[ST_ERL_BIT] = 1'b0;
				end
			end
		end else if (pick < 96)
			r = random_fields(MODE_REG_READ);
		else
			r = random_fields(4'($urandom_range(MODE_REG_READ + 1, 15)));
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		if (n_errors < MAX_PRINTED)
			$display("MISMATCH at %0t: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send_item(input cp0_req_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cur_req <= r;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
	endtask

	task automatic write_reg(input logic [3:0] sel, input logic [63:0] value);
		cp0_req_t r;
		r = random_fields(MODE_REG_WRITE);
		r.sel = sel;
		r.wdata = value;
		send_item(r);
	endtask

	task automatic test_exception_entry();
		cp0_req_t r;
		// Delay slot at address zero: EPC wraps around.
		r = random_fields(MODE_COP_UNUSABLE);
		r.fault_pc = '0;
		r.bd = 1'b1;
		send_item(r);
		// Nested entry goes to ErrorEPC.
		send_item(random_fields(MODE_SYSCALL));
		write_reg(SEL_STATUS, 64'h0040_00F8);
		r = random_fields(MODE_DTLB);
		{r.miss, r.invalid, r.modified, r.is_store} = 4'b1001;
		r.bad_vaddr = '1;
		r.segmask = 8'h80;
		send_item(r);
		write_reg(SEL_STATUS, '0);
		r = random_fields(MODE_DTLB);
		{r.miss, r.invalid, r.modified, r.is_store} = 4'b1000;
		r.bad_vaddr = 64'h0000_0000_FFFF_E000;
		r.segmask = 8'hFF;
		send_item(r);
		write_reg(SEL_STATUS, '0);
		r = random_fields(MODE_DTLB);
		{r.miss, r.invalid, r.modified, r.is_store} = 4'b0101;
		send_item(r);
		r = random_fields(MODE_DTLB);
		{r.miss, r.invalid, r.modified, r.is_store} = 4'b0010;
		send_item(r);
		// Refill miss while EXL is already set uses the general offset.
		r = random_fields(MODE_DTLB);
		{r.miss, r.invalid, r.modified, r.is_store} = 4'b1000;
		send_item(r);
		write_reg(SEL_STATUS, '0);
		r = random_fields(MODE_ITLB);
		r.miss = 1'b1;
		r.fault_pc = '1;
		r.bd = 1'b0;
		send_item(r);
		write_reg(SEL_STATUS, '0);
		r = random_fields(MODE_INTERRUPT);
		r.fault_pc = 64'd2;
		r.bd = 1'b1;
		send_item(r);
		send_item(random_fields(MODE_WATCH));
	endtask

	task automatic test_register_access();
		cp0_req_t r;
		write_reg(SEL_CONFIG, '1);
		send_item(random_fields(MODE_COLD_RESET));
		write_reg(SEL_RANDOM, '1);
		write_reg(4'hF, '1);
		send_item(random_fields(MODE_REG_READ + 1));
		send_item(random_fields(4'hF));
		// Every register once, then a select past the last register.
		for (int i = 0; i <= 10; i++) begin
			r = random_fields(MODE_REG_READ);
			r.sel = (i == 10) ? 4'hC : 4'(i);
			send_item(r);
		end
		r = random_fields(MODE_REG_READ);
		r.sel = SEL_CONFIG;
		send_item(r);
	endtask

	task automatic test_random_mix(input int n_items);
		repeat (n_items)
			send_item(random_cp0_item());
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			pending_results.push_back(cp0_step_result(cur_req));
			if (cur_req.mode <= MODE_COLD_RESET)
				n_events++;
			else if (cur_req.mode == MODE_REG_WRITE)
				n_writes++;
			else if (cur_req.mode == MODE_REG_READ)
				n_reads++;
			else
				n_other++;
		end
	end

	always @(posedge clk) begin : check_results
		cp0e_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with no item pending", n_checked));
			end else begin
				want = pending_results.pop_front();
				if (next_pc !== want.next_pc)
					report_mismatch($sformatf("result %0d next_pc got %h expected %h",
						n_checked, next_pc, want.next_pc));
				if (exception_code !== want.exception_code)
					report_mismatch($sformatf("result %0d exception_code got %0d expected %0d",
						n_checked, exception_code, want.exception_code));
				if (read_data !== want.read_data)
					report_mismatch($sformatf("result %0d read_data got %h expected %h",
						n_checked, read_data, want.read_data));
			end
			n_checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 15;
		recv_stall_pct = 49;
		test_exception_entry();
		test_register_access();
		test_random_mix(230);
		send_idle_pct = 49;
		recv_stall_pct = 15;
		test_random_mix(230);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random_mix(230);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		$display("Sent %0d exception entries, %0d register writes, %0d reads, %0d unused modes",
			n_events, n_writes, n_reads, n_other);
		$display("Checked %0d results, %0d mismatches", n_checked, n_errors);
		if (n_errors == 0 && pending_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
